// File: design/assert_macros.svh
// Assertion macros shared by the transcoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: design/u8u16_pkg.sv
// Types and constants of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // Most code units that one input byte can produce.
  localparam int unsigned MaxUnits = 4;

  // Replacement character sent for each decoding error.
  localparam logic [15:0] REPL_CHAR = 16'hFFFD;

  // Scalar limits.
  localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [20:0] SUR_FIRST  = 21'h00D800;
  localparam logic [20:0] SUR_LAST   = 21'h00DFFF;
  localparam logic [20:0] PLANE1     = 21'h010000;
  localparam logic [20:0] MIN_LEN2   = 21'h000080;
  localparam logic [20:0] MIN_LEN3   = 21'h000800;

  // Surrogate bases.
  localparam logic [15:0] HI_SUR_BASE = 16'hD800;
  localparam logic [15:0] LO_SUR_BASE = 16'hDC00;

  // Lead byte classes.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  // Pending sequence lengths.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Code units produced by one byte, handed to the output buffer.
  typedef struct packed {
    logic [2:0]       cnt;
    logic [3:0][15:0] units;
  } res_t;

endpackage

// File: design/u8u16_decode.sv
// Sequence state and combinational decode of one UTF-8 byte.
`include "assert_macros.svh"

module u8u16_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output u8u16_pkg::res_t    res_o
);

  logic [2:0]  len_q, len_d;
  logic [1:0]  cc_q, cc_d;
  logic [20:0] ps_q, ps_d;

  logic        lead_multi;
  logic        lead_emit;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;
  logic [15:0] lead_unit;

  logic        is_cont;
  logic        complete;
  logic        bad;
  logic [20:0] cp;
  logic [20:0] cp_min;
  logic [20:0] cp_off;
  logic [2:0]  slot;
  logic        len_legal;
  logic        pend_ok;

  // Classify the byte as a lead.
  always_comb begin
    lead_multi = 1'b0;
    lead_emit  = 1'b0;
    lead_len   = u8u16_pkg::LEN_NONE;
    lead_bits  = '0;
    lead_unit  = u8u16_pkg::REPL_CHAR;
    if (!byte_i[7]) begin
      lead_emit = 1'b1;
      lead_unit = {8'h00, byte_i};
    end else if ((byte_i & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
      lead_multi = 1'b1;
      lead_len   = u8u16_pkg::LEN_TWO;
      lead_bits  = {16'h0000, byte_i[4:0]};
    end else if ((byte_i & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
      lead_multi = 1'b1;
      lead_len   = u8u16_pkg::LEN_THREE;
      lead_bits  = {17'h0, byte_i[3:0]};
    end else if ((byte_i & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
      lead_multi = 1'b1;
      lead_len   = u8u16_pkg::LEN_FOUR;
      lead_bits  = {18'h0, byte_i[2:0]};
    end else begin
      lead_emit = 1'b1;
    end
    // A lead on the final byte is a truncated sequence.
    if (lead_multi && last_i) begin
      lead_emit = 1'b1;
    end
  end

  // Scalar checks for a sequence that completes with this byte.
  assign is_cont  = (byte_i & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_CODE;
  assign complete = ({1'b0, cc_q} + 3'd2) >= len_q;
  assign cp       = {ps_q[14:0], byte_i[5:0]};
  assign cp_off   = cp - u8u16_pkg::PLANE1;

  always_comb begin
    case (len_q)
      u8u16_pkg::LEN_TWO:   cp_min = u8u16_pkg::MIN_LEN2;
      u8u16_pkg::LEN_THREE: cp_min = u8u16_pkg::MIN_LEN3;
      default:              cp_min = u8u16_pkg::PLANE1;
    endcase
  end

  assign bad = (cp < cp_min) || (cp > u8u16_pkg::MAX_SCALAR) ||
               ((cp >= u8u16_pkg::SUR_FIRST) && (cp <= u8u16_pkg::SUR_LAST));

  // Results and next state.
  always_comb begin
    res_o.units = {4{u8u16_pkg::REPL_CHAR}};
    res_o.cnt   = 3'd0;
    len_d       = len_q;
    cc_d        = cc_q;
    ps_d        = ps_q;
    slot        = 3'd0;
    if ((len_q != u8u16_pkg::LEN_NONE) && is_cont) begin
      if (complete) begin
        len_d = u8u16_pkg::LEN_NONE;
        cc_d  = 2'd0;
        ps_d  = '0;
        if (bad) begin
          // One replacement per byte of the sequence.
          res_o.cnt = len_q;
        end else if (cp > 21'h00FFFF) begin
          res_o.cnt      = 3'd2;
          res_o.units[0] = u8u16_pkg::HI_SUR_BASE | {6'b000000, cp_off[19:10]};
          res_o.units[1] = u8u16_pkg::LO_SUR_BASE | {6'b000000, cp_off[9:0]};
        end else begin
          res_o.cnt      = 3'd1;
          res_o.units[0] = cp[15:0];
        end
      end else if (last_i) begin
        // Truncated: lead plus every held continuation, this one included.
        res_o.cnt = {1'b0, cc_q} + 3'd2;
        len_d     = u8u16_pkg::LEN_NONE;
        cc_d      = 2'd0;
        ps_d      = '0;
      end else begin
        cc_d = cc_q + 2'd1;
        ps_d = cp;
      end
    end else begin
      // A broken sequence fails first, then the byte is read as a lead.
      if (len_q != u8u16_pkg::LEN_NONE) begin
        slot = {1'b0, cc_q} + 3'd1;
      end
      if (lead_emit) begin
        res_o.units[slot[1:0]] = lead_unit;
        res_o.cnt              = slot + 3'd1;
      end else begin
        res_o.cnt = slot;
      end
      if (lead_multi && !last_i) begin
        len_d = lead_len;
        cc_d  = 2'd0;
        ps_d  = lead_bits;
      end else begin
        len_d = u8u16_pkg::LEN_NONE;
        cc_d  = 2'd0;
        ps_d  = '0;
      end
    end
  end

  // State registers advance only when a byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= u8u16_pkg::LEN_NONE;
      cc_q  <= 2'd0;
      ps_q  <= '0;
    end else if (fire_i) begin
      len_q <= len_d;
      cc_q  <= cc_d;
      ps_q  <= ps_d;
    end
  end

  // A pending length is one of the multi-byte forms and still misses a byte.
  assign len_legal = (len_q == u8u16_pkg::LEN_TWO) || (len_q == u8u16_pkg::LEN_THREE) ||
                     (len_q == u8u16_pkg::LEN_FOUR);
  assign pend_ok   = (len_q == u8u16_pkg::LEN_NONE) ||
                     (len_legal && (({1'b0, cc_q} + 3'd1) < len_q));

  // An idle decoder holds no continuation bytes.
  `ASSERT_AT(idle_no_cont, clk_i, rst_ni, (len_q != u8u16_pkg::LEN_NONE) || (cc_q == 2'd0))
  // A pending sequence always still misses at least one continuation byte.
  `ASSERT_AT(pending_short, clk_i, rst_ni, pend_ok)
  // One byte never yields more than four code units.
  `ASSERT_AT(res_bound, clk_i, rst_ni, res_o.cnt <= 3'd4)

endmodule

// File: design/u8u16_burst.sv
// Output buffer that plays out the code units of one byte, one word a cycle while out_stall_i is low.
`include "assert_macros.svh"

module u8u16_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  u8u16_pkg::res_t res_i,
  input  logic            end_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [15:0]     code_unit_o,
  output logic            run_last_o,
  output logic            text_end_o
);

  logic [3:0][15:0] units_q;
  logic [2:0]       rem_q;
  logic             end_q;
  logic             pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = rem_q != 3'd0;
  assign code_unit_o = units_q[0];
  assign run_last_o  = rem_q == 3'd1;
  assign text_end_o  = (rem_q == 3'd1) && end_q;

  // Room for a new burst once the last word leaves this cycle.
  assign free_o = (rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall_i);

  // Remaining-word count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else if (load_i) begin
      rem_q <= res_i.cnt;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  // Word shift line; the head word is always on the port.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      units_q <= res_i.units;
      end_q   <= end_i;
    end else if (pop) begin
      units_q <= {u8u16_pkg::REPL_CHAR, units_q[3:1]};
    end
  end

  // A burst is loaded only into a buffer that is empty or draining its last word.
  `ASSERT_AT(load_when_free, clk_i, rst_ni, load_i |-> ((rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall_i)))
  // Loaded bursts carry one to four words.
  `ASSERT_AT(load_count, clk_i, rst_ni, load_i |-> ((res_i.cnt != 3'd0) && (res_i.cnt <= 3'd4)))
  // A taken final word without a new load empties the buffer.
  `ASSERT_AT(drain_empty, clk_i, rst_ni, ((rem_q == 3'd1) && !out_stall_i && !load_i) |=> (rem_q == 3'd0))

endmodule

// File: design/utf8_to_utf16_decoder_core.sv
// Top level of the streaming UTF-8 to UTF-16 transcoder.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_byte_i, last_byte_i  | byte in
//  out     | out_valid_o, out_stall_i, code_unit_o,          | word out
//          | run_last_o, text_end_o                          |
//
// A byte is registered at the input, decoded combinationally against the sequence
// state, and its code units are loaded into the output buffer when it is consumed.
// Throughput is one byte per cycle while each byte makes at most one word and the
// output does not stall; a byte that makes more words holds the input until its last word leaves.
// An accepted byte is registered in the input stage, and its words in the output buffer.
// Reset clears the input stage, the sequence state and the output buffer.
// A stall at the output backs up into in_stall_o once the input stage is full.

module utf8_to_utf16_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        run_last_o,
  output logic        text_end_o
);

  logic            in_vq;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            accept;
  logic            fire;
  logic            free;
  u8u16_pkg::res_t res;

  // A registered byte is consumed when its words fit in the output buffer.
  assign fire       = in_vq && ((res.cnt == 3'd0) || free);
  assign in_stall_o = in_vq && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  // Input stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (accept) begin
      in_vq <= 1'b1;
    end else if (fire) begin
      in_vq <= 1'b0;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  u8u16_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && (res.cnt != 3'd0)),
    .res_i       (res),
    .end_i       (last_q),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

endmodule

// File: dv/utf8_to_utf16_decoder_core_test.sv
// Self-checking testbench of the streaming UTF-8 to UTF-16 transcoder core.
module utf8_to_utf16_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output word.
  typedef struct packed {
    logic [15:0] unit;
    logic        run_last;
    logic        text_end;
  } unit_exp_t;

  // Mirror of the decoder state; it predicts the code units of every accepted byte
  // and matches them against what the core emits.
  class utf16_transcoder_mirror;
    logic [2:0]  seq_len;
    logic [1:0]  cont_cnt;
    logic [20:0] partial;
    logic [15:0] step_units[$];
    unit_exp_t   units_due[$];
    int unsigned bytes_seen;
    int unsigned units_matched;
    int unsigned repl_seen;
    int unsigned mismatches;

    function new();
      clear_seq();
      bytes_seen = 0;
      units_matched = 0;
      repl_seen = 0;
      mismatches = 0;
    endfunction

    function void clear_seq();
      seq_len = u8u16_pkg::LEN_NONE;
      cont_cnt = '0;
      partial = '0;
    endfunction

    function void put_unit(logic [15:0] u);
      if (step_units.size() < u8u16_pkg::MaxUnits) step_units.push_back(u);
    endfunction

    // One replacement for the failed lead and one per held continuation byte.
    function void fail_seq();
      put_unit(u8u16_pkg::REPL_CHAR);
      for (int k = 0; k < int'(cont_cnt); k++) put_unit(u8u16_pkg::REPL_CHAR);
      clear_seq();
    endfunction

    // Decode a byte that arrives while no sequence is pending.
    function void start_lead(logic [7:0] b, logic last);
      if (b[7] == 1'b0) begin
        put_unit({8'h00, b});
        return;
      end
      if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
        seq_len = u8u16_pkg::LEN_TWO;
        partial = {16'h0, b[4:0]};
      end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
        seq_len = u8u16_pkg::LEN_THREE;
        partial = {17'h0, b[3:0]};
      end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
        seq_len = u8u16_pkg::LEN_FOUR;
        partial = {18'h0, b[2:0]};
      end else begin
        put_unit(u8u16_pkg::REPL_CHAR);
        return;
      end
      cont_cnt = '0;
      // A lead that ends the text is truncated at once.
      if (last) begin
        put_unit(u8u16_pkg::REPL_CHAR);
        clear_seq();
      end
    endfunction

    // The sequence has all its bytes: reject overlong, surrogate and out-of-range values.
    function void complete_seq();
      logic [20:0] floor_cp;
      logic [20:0] cp;
      cp = partial;
      case (seq_len)
        u8u16_pkg::LEN_TWO:   floor_cp = u8u16_pkg::MIN_LEN2;
        u8u16_pkg::LEN_THREE: floor_cp = u8u16_pkg::MIN_LEN3;
        default:              floor_cp = u8u16_pkg::PLANE1;
      endcase
      if (cp < floor_cp || cp > u8u16_pkg::MAX_SCALAR ||
          (cp >= u8u16_pkg::SUR_FIRST && cp <= u8u16_pkg::SUR_LAST)) begin
        fail_seq();
        return;
      end
      if (cp >= u8u16_pkg::PLANE1) begin
        cp = cp - u8u16_pkg::PLANE1;
        put_unit(u8u16_pkg::HI_SUR_BASE + 16'(cp >> 10));
        put_unit(u8u16_pkg::LO_SUR_BASE + 16'(cp & 21'h0003FF));
      end else begin
        put_unit(cp[15:0]);
      end
      clear_seq();
    endfunction

    // Note one accepted input byte and queue the code units it causes.
    function void take_byte(logic [7:0] b, logic last);
      step_units.delete();
      bytes_seen++;
      if (seq_len == u8u16_pkg::LEN_NONE) begin
        start_lead(b, last);
      end else if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_CODE) begin
        partial = {partial[14:0], b[5:0]};
        cont_cnt = cont_cnt + 2'd1;
        if (int'(cont_cnt) + 1 >= int'(seq_len)) complete_seq();
        else if (last) fail_seq();
      end else begin
        // A broken sequence is flushed and the byte is read again as a lead.
        fail_seq();
        start_lead(b, last);
      end
      foreach (step_units[k]) begin
        units_due.push_back('{unit: step_units[k],
                              run_last: (k == step_units.size() - 1),
                              text_end: (k == step_units.size() - 1) && last});
        if (step_units[k] == u8u16_pkg::REPL_CHAR) repl_seen++;
      end
    endfunction

    // Compare one emitted word with the oldest expected one.
    function void match_unit(logic [15:0] u, logic rl, logic te);
      unit_exp_t e;
      if (units_due.size() == 0) begin
        $error("code_unit %h emitted while no word was expected", u);
        mismatches++;
        return;
      end
      e = units_due.pop_front();
      units_matched++;
      if (u !== e.unit) begin
        $error("code_unit mismatch: expected %h, actual %h", e.unit, u);
        mismatches++;
      end
      if (rl !== e.run_last) begin
        $error("run_last mismatch: expected %b, actual %b", e.run_last, rl);
        mismatches++;
      end
      if (te !== e.text_end) begin
        $error("text_end mismatch: expected %b, actual %b", e.text_end, te);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] code_unit_o;
  logic        run_last_o;
  logic        text_end_o;

  utf16_transcoder_mirror chk;
  int unsigned in_gap_pct = 13;
  int unsigned out_gap_pct = 64;
  int unsigned bytes_sent = 0;

  utf8_to_utf16_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver stalls at random with the current rate.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_gap_pct);
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && chk != null) begin
      if (in_valid_i && !in_stall_o) chk.take_byte(in_byte_i, last_byte_i);
      if (out_valid_o && !out_stall_i) chk.match_unit(code_unit_o, run_last_o, text_end_o);
    end
  end

  // Offer one input byte after a random gap and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic pick_last();
    return $urandom_range(24) == 0;
  endfunction

  // Send the UTF-8 encoding of a scalar; a random text end may truncate it.
  task automatic send_scalar(input logic [20:0] cp);
    if (cp < 21'h80) begin
      send_byte(cp[7:0], pick_last());
    end else if (cp < 21'h800) begin
      send_byte({3'b110, cp[10:6]}, pick_last());
      send_byte({2'b10, cp[5:0]}, pick_last());
    end else if (cp < 21'h10000) begin
      send_byte({4'b1110, cp[15:12]}, pick_last());
      send_byte({2'b10, cp[11:6]}, pick_last());
      send_byte({2'b10, cp[5:0]}, pick_last());
    end else begin
      send_byte({5'b11110, cp[20:18]}, pick_last());
      send_byte({2'b10, cp[17:12]}, pick_last());
      send_byte({2'b10, cp[11:6]}, pick_last());
      send_byte({2'b10, cp[5:0]}, pick_last());
    end
  endtask

  // Mostly well-formed characters, otherwise malformed sequences and raw noise.
  task automatic send_random_item();
    int unsigned pick;
    int unsigned len;
    int unsigned n_cont;
    logic [20:0] cp;
    logic [7:0]  lead;
    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(3))
        0: cp = 21'($urandom_range(8'h7F));
        1: cp = 21'($urandom_range(16'h07FF, 16'h0080));
        2: begin
          cp = 21'($urandom_range(16'hFFFF, 16'h0800));
          if (cp >= u8u16_pkg::SUR_FIRST && cp <= u8u16_pkg::SUR_LAST) cp = cp ^ 21'h004000;
        end
        default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
      endcase
      send_scalar(cp);
    end else if (pick < 82) begin
      // Random lead class and payload: overlong, surrogate, too large or cut short.
      len = $urandom_range(4, 2);
      case (len)
        2:       lead = {3'b110, 5'($urandom)};
        3:       lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_byte(lead, pick_last());
      n_cont = $urandom_range(len - 1, (pick < 72) ? len - 1 : 0);
      repeat (n_cont) send_byte({2'b10, 6'($urandom)}, pick_last());
    end else begin
      send_byte(8'($urandom_range(255)), pick_last());
    end
  endtask

  // Hold the input idle until every expected word has come out.
  task automatic hold_until_drained(input int unsigned limit);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (limit) begin
      if (chk.units_due.size() == 0) break;
      @(posedge clk_i);
    end
  endtask

  initial begin
    // Valid one-, two- and four-byte characters, each error kind and both truncation forms;
    // bit 8 marks the end of the text.
    logic [8:0] script[] = '{
      9'h0C2, 9'h0A9,                  // two-byte character
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // highest scalar as a surrogate pair
      9'h0FF,                          // invalid lead
      9'h0C0, 9'h080,                  // overlong form
      9'h0ED, 9'h0A0, 9'h080,          // encoded surrogate
      9'h0F4, 9'h090, 9'h080, 9'h080,  // above the highest scalar
      9'h0F0, 9'h09F, 9'h098, 9'h041,  // bad continuation after two held bytes
      9'h0E2, 9'h182,                  // text ends on a continuation
      9'h1F0,                          // text ends on a lead
      9'h000, 9'h17F                   // lowest and highest ASCII
    };
    chk = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);

    // Sender idles often less than the receiver, then the reverse, then no idling.
    while (bytes_sent < 75) send_random_item();
    hold_until_drained(5000);
    in_gap_pct = 64;
    out_gap_pct = 13;
    while (bytes_sent < 130) send_random_item();
    hold_until_drained(5000);
    in_gap_pct = 0;
    out_gap_pct = 0;
    while (bytes_sent < 180) send_random_item();

    hold_until_drained(5000);
    repeat (10) @(posedge clk_i);
    if (chk.units_due.size() != 0) begin
      $error("%0d expected code units never arrived", chk.units_due.size());
      chk.mismatches += chk.units_due.size();
    end

    $display("Fed %0d UTF-8 bytes under three stall mixes; %0d UTF-16 words were checked.",
             chk.bytes_seen, chk.units_matched);
    $display("%0d of the predicted words were replacement characters.", chk.repl_seen);
    if (chk.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #500us;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
